// ----- hw/rtl/hfla_pkg.sv -----
// shared types and constants for the handle free-list allocator
// used by hfla_cell, handle_free_list_allocator and hfla_checker
package hfla_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HANDLE_W = 9;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // stack shift controls broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } hfla_shift_t;

  // search token that walks down the chain one cell per cycle
  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] key;
    logic [CNT_W-1:0]  left;
    logic              hit;
  } hfla_token_t;

endpackage

// ----- hw/rtl/hfla_cell.sv -----
// one stack cell: holds one free-stack entry and one stage of the search token
// depends on hfla_pkg
module hfla_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hfla_pkg::hfla_shift_t        shift,
  input  logic [hfla_pkg::SLOT_W-1:0]  prev_entry,
  input  logic [hfla_pkg::SLOT_W-1:0]  next_entry,
  input  hfla_pkg::hfla_token_t        tok_in,
  output logic [hfla_pkg::SLOT_W-1:0]  entry,
  output hfla_pkg::hfla_token_t        tok_out
);

  logic [hfla_pkg::SLOT_W-1:0] entry_r, entry_nxt;
  hfla_pkg::hfla_token_t       tok_r, tok_nxt;
  logic                        occupied;

  always_comb begin
    entry_nxt = entry_r;
    if (shift.push) begin
      entry_nxt = prev_entry;
    end else if (shift.pop) begin
      entry_nxt = next_entry;
    end
  end

  // left counts the occupied cells still ahead of the token
  assign occupied = (tok_in.left != '0);

  always_comb begin
    tok_nxt        = tok_in;
    tok_nxt.left   = occupied ? tok_in.left - 1'b1 : tok_in.left;
    tok_nxt.hit    = tok_in.hit | (occupied & (entry_r == tok_in.key));
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign entry   = entry_r;
  assign tok_out = tok_r;

endmodule

// ----- hw/rtl/handle_free_list_allocator.sv -----
// allocate: result is registered, one item per cycle while in_stall is low
// release of an in-range handle: the search token walks the whole cell
//   chain first; a release that is out of range is answered without a search
// no new item is taken while a release search runs
// reset (rst_n low, synchronous) empties the stack and the high-water count;
//   stack cell contents are not cleared
module handle_free_list_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [hfla_pkg::HANDLE_W-1:0] in_handle_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hfla_pkg::HANDLE_W-1:0] out_handle_out,
  output logic                          out_release_ok
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                          state_r, state_nxt;
  logic [hfla_pkg::CNT_W-1:0]    free_count_r, free_count_nxt;
  logic [hfla_pkg::CNT_W-1:0]    high_water_r, high_water_nxt;
  logic [hfla_pkg::SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [hfla_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                          out_ok_r, out_ok_nxt;

  logic                          in_acc;
  logic [hfla_pkg::HANDLE_W-1:0] handle_m1;
  logic                          in_range;
  logic                          search_done;
  hfla_pkg::hfla_shift_t         shift;

  logic [hfla_pkg::SLOT_W-1:0]   ent [hfla_pkg::CAPACITY];
  hfla_pkg::hfla_token_t         tok [hfla_pkg::CAPACITY+1];

  assign in_stall    = (state_r != ST_IDLE) | (out_valid_r & out_stall);
  assign in_acc      = in_valid & ~in_stall;
  assign handle_m1   = in_handle_in - 1'b1;
  assign in_range    = (in_handle_in != '0) &&
                       (handle_m1 < hfla_pkg::HANDLE_W'(high_water_r));
  assign search_done = (state_r == ST_SEARCH) & tok[hfla_pkg::CAPACITY].active;

  // token enters cell 0 on an in-range release
  always_comb begin
    tok[0].active = in_acc & (in_action == hfla_pkg::ACT_RELEASE) & in_range;
    tok[0].key    = handle_m1[hfla_pkg::SLOT_W-1:0];
    tok[0].left   = free_count_r;
    tok[0].hit    = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    free_count_nxt = free_count_r;
    high_water_nxt = high_water_r;
    pend_slot_nxt  = pend_slot_r;
    out_handle_nxt = out_handle_r;
    out_ok_nxt     = out_ok_r;
    out_valid_nxt  = out_valid_r & out_stall;
    shift.push     = 1'b0;
    shift.pop      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == hfla_pkg::ACT_ALLOC) begin
            out_valid_nxt  = 1'b1;
            out_ok_nxt     = 1'b0;
            out_handle_nxt = '0;
            if (free_count_r != '0) begin
              // top of stack sits in cell 0
              shift.pop      = 1'b1;
              free_count_nxt = free_count_r - 1'b1;
              out_handle_nxt = hfla_pkg::HANDLE_W'(ent[0]) + 1'b1;
            end else if (high_water_r != hfla_pkg::CNT_W'(hfla_pkg::CAPACITY)) begin
              high_water_nxt = high_water_r + 1'b1;
              out_handle_nxt = hfla_pkg::HANDLE_W'(high_water_r) + 1'b1;
            end
          end else if (in_range) begin
            pend_slot_nxt = handle_m1[hfla_pkg::SLOT_W-1:0];
            state_nxt     = ST_SEARCH;
          end else begin
            out_valid_nxt  = 1'b1;
            out_ok_nxt     = 1'b0;
            out_handle_nxt = '0;
          end
        end
      end
      ST_SEARCH: begin
        if (search_done) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_handle_nxt = '0;
          out_ok_nxt     = 1'b0;
          if (!tok[hfla_pkg::CAPACITY].hit &&
              (free_count_r != hfla_pkg::CNT_W'(hfla_pkg::CAPACITY))) begin
            shift.push     = 1'b1;
            free_count_nxt = free_count_r + 1'b1;
            out_ok_nxt     = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < hfla_pkg::CAPACITY; gi++) begin : g_cell
      logic [hfla_pkg::SLOT_W-1:0] prev_e, next_e;
      if (gi == 0) begin : g_first
        assign prev_e = pend_slot_r;
      end else begin : g_mid
        assign prev_e = ent[gi-1];
      end
      if (gi == hfla_pkg::CAPACITY - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = ent[gi+1];
      end
      hfla_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (shift),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .tok_in     (tok[gi]),
        .entry      (ent[gi]),
        .tok_out    (tok[gi+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    pend_slot_r  <= pend_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_ok_r     <= out_ok_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_count_r <= '0;
      high_water_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_count_r <= free_count_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_release_ok = out_ok_r;

endmodule

// ----- hw/rtl/hfla_checker.sv -----
// port-level assertions for handle_free_list_allocator, bound to the top level
// depends on hfla_pkg
module hfla_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_action,
  input logic [hfla_pkg::HANDLE_W-1:0] in_handle_in,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [hfla_pkg::HANDLE_W-1:0] out_handle_out,
  input logic                          out_release_ok
);

  // an accepted release never also hands out a handle
  a_ok_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_release_ok |-> out_handle_out == '0)
    else $error("release result carries a handle");

  // allocate answers in the next cycle
  a_alloc_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == hfla_pkg::ACT_ALLOC |=> out_valid)
    else $error("allocate result missing one cycle after accept");

  // release of handle zero is rejected at once
  a_zero_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == hfla_pkg::ACT_RELEASE &&
    in_handle_in == '0 |=> out_valid && !out_release_ok && out_handle_out == '0)
    else $error("release of handle zero not rejected");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_handle_out) &&
    $stable(out_release_ok))
    else $error("stalled result changed");

endmodule

bind handle_free_list_allocator hfla_checker u_hfla_checker (.*);
